// ----- rtl/core/lfb_pkg.sv -----
// Shared types and constants of the line-follow bar sequencer.
// Used by lfb_regs, lfb_step, the top level and the port checker.
// No dependencies.
package lfb_pkg;

    localparam int SENSOR_COUNT = 6;
    localparam int MASK_W       = 6;
    localparam int BLACK_CNT_W  = 3;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;
    localparam int IN_DATA_W    = 16;
    localparam int OUT_DATA_W   = 56;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WAIT  = 2'd1,
        PH_LEAVE = 2'd2,
        PH_TRACK = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE     = 2'd0,
        CMD_STOP     = 2'd1,
        CMD_STRAIGHT = 2'd2,
        CMD_FOLLOW   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        WHY_NONE    = 3'd0,
        WHY_CANCEL  = 3'd1,
        WHY_NOLINE  = 3'd2,
        WHY_IDLE    = 3'd3,
        WHY_STOPBAR = 3'd4
    } t_reason;

    typedef enum logic [2:0] {
        REG_BAR_MIN       = 3'd0,
        REG_BAR_MAX       = 3'd1,
        REG_START_CONFIRM = 3'd2,
        REG_LEAVE_CONFIRM = 3'd3,
        REG_STOP_CONFIRM  = 3'd4,
        REG_STOP_ARM_MS   = 3'd5,
        REG_TICK_MS       = 3'd6,
        REG_STRAIGHT_RPM  = 3'd7
    } t_reg_idx;

    localparam logic [1:0]  CHIRP_NONE  = 2'd0;
    localparam logic [1:0]  CHIRP_ARM   = 2'd1;
    localparam logic [1:0]  CHIRP_BAR   = 2'd2;
    localparam logic [7:0]  CONFIRM_MAX = 8'hFF;
    localparam logic [9:0]  DEFAULT_RPM = 10'd80;
    localparam logic [31:0] RUN_MS_MAX  = 32'hFFFF_FFFF;

    localparam logic [2:0]  RST_BAR_MIN       = 3'd5;
    localparam logic [2:0]  RST_BAR_MAX       = 3'd6;
    localparam logic [7:0]  RST_START_CONFIRM = 8'd3;
    localparam logic [7:0]  RST_LEAVE_CONFIRM = 8'd2;
    localparam logic [7:0]  RST_STOP_CONFIRM  = 8'd3;
    localparam logic [15:0] RST_STOP_ARM_MS   = 16'd800;
    localparam logic [9:0]  RST_TICK_MS       = 10'd20;
    localparam logic [9:0]  RST_STRAIGHT_RPM  = 10'd80;

    typedef struct packed {
        logic [2:0]  bar_min_black;
        logic [2:0]  bar_max_black;
        logic [7:0]  start_confirm_ticks;
        logic [7:0]  leave_confirm_ticks;
        logic [7:0]  stop_confirm_ticks;
        logic [15:0] stop_arm_ms;
        logic [9:0]  tick_period_ms;
        logic [9:0]  straight_rpm;
    } t_cfg;

    typedef struct packed {
        logic              action;
        logic [MASK_W-1:0] black_mask;
        logic              line_ready;
        logic              line_enabled;
        logic              drive_enabled;
        logic              chassis_active;
        logic              follow_active;
    } t_item;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  confirm_count;
        logic [31:0] run_ms;
    } t_state;

    typedef struct packed {
        t_cmd        motor_cmd;
        logic [9:0]  drive_rpm;
        logic [1:0]  chirp_count;
        t_reason     stop_reason;
        logic        run_time_valid;
        logic [31:0] run_time_ms;
        t_phase      run_phase;
    } t_result;

endpackage

// ----- rtl/core/line_follow_bar_sequencer.sv -----
// Top level of the line-follow bar sequencer: stream input register,
// sequencer state, result register. Uses lfb_pkg, lfb_regs and lfb_step.
//
//  Channel   | Direction | Handshake                    | Payload
//  ----------+-----------+------------------------------+-------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: sensors+flags, tuser: action
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: one result per input beat
//  APB       | in        | psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// An input beat passes the input register, then the result register; one beat
// per cycle is sustained while m_axis is ready, set by the single decision
// stage between the input and result registers. The state register updates as
// a beat moves into the result register. Reset clears state and valids, not
// the data registers. A stalled m_axis holds its result while one further input beat is held.
module line_follow_bar_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] black_mask, [6] line_ready, [7] line_enabled, [8] drive_enabled,
    // [9] chassis_active, [10] follow_active, [15:11] zero
    input  logic [lfb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // [0] action
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [1:0] motor_cmd, [11:2] drive_rpm, [13:12] chirp_count, [16:14] stop_reason,
    // [17] run_time_valid, [49:18] run_time_ms, [51:50] run_phase, [55:52] zero
    output logic [lfb_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lfb_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lfb_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lfb_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    lfb_pkg::t_cfg    w_cfg;
    lfb_pkg::t_item   w_in_item;
    lfb_pkg::t_item   r_item;
    logic             r_in_valid;
    logic             n_in_valid;
    lfb_pkg::t_state  r_state;
    lfb_pkg::t_state  n_state;
    lfb_pkg::t_result n_result;
    lfb_pkg::t_result r_result;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             w_in_acc;
    logic             w_adv;

    lfb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    lfb_step u_step (
        .i_state  (r_state),
        .i_cfg    (w_cfg),
        .i_item   (r_item),
        .o_state  (n_state),
        .o_result (n_result)
    );

    assign w_in_item.action         = s_axis_tuser[0];
    assign w_in_item.black_mask     = s_axis_tdata[lfb_pkg::MASK_W-1:0];
    assign w_in_item.line_ready     = s_axis_tdata[6];
    assign w_in_item.line_enabled   = s_axis_tdata[7];
    assign w_in_item.drive_enabled  = s_axis_tdata[8];
    assign w_in_item.chassis_active = s_axis_tdata[9];
    assign w_in_item.follow_active  = s_axis_tdata[10];

    // advance the held beat when the result register is free or draining
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;

    assign n_in_valid  = w_in_acc ? 1'b1 : (w_adv ? 1'b0 : r_in_valid);
    assign n_out_valid = w_adv ? 1'b1 : (m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_state.phase         <= lfb_pkg::PH_IDLE;
            r_state.confirm_count <= 8'd0;
            r_state.run_ms        <= 32'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_item <= w_in_item;
        end
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_result.run_phase, r_result.run_time_ms,
                            r_result.run_time_valid, r_result.stop_reason,
                            r_result.chirp_count, r_result.drive_rpm, r_result.motor_cmd};

endmodule

// ----- rtl/core/lfb_regs.sv -----
// APB configuration registers of the line-follow bar sequencer.
// Depends on lfb_pkg for the register map and the t_cfg struct.
module lfb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lfb_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lfb_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lfb_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output lfb_pkg::t_cfg                    o_cfg
);

    lfb_pkg::t_cfg    r_cfg;
    lfb_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = lfb_pkg::t_reg_idx'(paddr[lfb_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bar_min_black       <= lfb_pkg::RST_BAR_MIN;
            r_cfg.bar_max_black       <= lfb_pkg::RST_BAR_MAX;
            r_cfg.start_confirm_ticks <= lfb_pkg::RST_START_CONFIRM;
            r_cfg.leave_confirm_ticks <= lfb_pkg::RST_LEAVE_CONFIRM;
            r_cfg.stop_confirm_ticks  <= lfb_pkg::RST_STOP_CONFIRM;
            r_cfg.stop_arm_ms         <= lfb_pkg::RST_STOP_ARM_MS;
            r_cfg.tick_period_ms      <= lfb_pkg::RST_TICK_MS;
            r_cfg.straight_rpm        <= lfb_pkg::RST_STRAIGHT_RPM;
        end else if (w_wr) begin
            unique case (w_idx)
                lfb_pkg::REG_BAR_MIN:       r_cfg.bar_min_black       <= pwdata[2:0];
                lfb_pkg::REG_BAR_MAX:       r_cfg.bar_max_black       <= pwdata[2:0];
                lfb_pkg::REG_START_CONFIRM: r_cfg.start_confirm_ticks <= pwdata[7:0];
                lfb_pkg::REG_LEAVE_CONFIRM: r_cfg.leave_confirm_ticks <= pwdata[7:0];
                lfb_pkg::REG_STOP_CONFIRM:  r_cfg.stop_confirm_ticks  <= pwdata[7:0];
                lfb_pkg::REG_STOP_ARM_MS:   r_cfg.stop_arm_ms         <= pwdata[15:0];
                lfb_pkg::REG_TICK_MS:       r_cfg.tick_period_ms      <= pwdata[9:0];
                lfb_pkg::REG_STRAIGHT_RPM:  r_cfg.straight_rpm        <= pwdata[9:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            lfb_pkg::REG_BAR_MIN:       prdata = {29'd0, r_cfg.bar_min_black};
            lfb_pkg::REG_BAR_MAX:       prdata = {29'd0, r_cfg.bar_max_black};
            lfb_pkg::REG_START_CONFIRM: prdata = {24'd0, r_cfg.start_confirm_ticks};
            lfb_pkg::REG_LEAVE_CONFIRM: prdata = {24'd0, r_cfg.leave_confirm_ticks};
            lfb_pkg::REG_STOP_CONFIRM:  prdata = {24'd0, r_cfg.stop_confirm_ticks};
            lfb_pkg::REG_STOP_ARM_MS:   prdata = {16'd0, r_cfg.stop_arm_ms};
            lfb_pkg::REG_TICK_MS:       prdata = {22'd0, r_cfg.tick_period_ms};
            lfb_pkg::REG_STRAIGHT_RPM:  prdata = {22'd0, r_cfg.straight_rpm};
        endcase
    end

endmodule

// ----- rtl/core/lfb_step.sv -----
// Per-beat decision logic: next sequencer state and result fields.
// Purely combinational; depends on lfb_pkg.
module lfb_step (
    input  lfb_pkg::t_state  i_state,
    input  lfb_pkg::t_cfg    i_cfg,
    input  lfb_pkg::t_item   i_item,
    output lfb_pkg::t_state  o_state,
    output lfb_pkg::t_result o_result
);

    localparam int USED_SENSORS = (lfb_pkg::SENSOR_COUNT < lfb_pkg::MASK_W) ?
                                  lfb_pkg::SENSOR_COUNT : lfb_pkg::MASK_W;

    function automatic logic [lfb_pkg::BLACK_CNT_W-1:0] count_black(
        input logic [lfb_pkg::MASK_W-1:0] mask
    );
        logic [lfb_pkg::BLACK_CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < USED_SENSORS; i++) begin
            n = n + {{(lfb_pkg::BLACK_CNT_W-1){1'b0}}, mask[i]};
        end
        return n;
    endfunction

    logic [lfb_pkg::BLACK_CNT_W-1:0] w_black;
    logic                            w_on_bar;
    logic [7:0]                      w_bumped;
    logic [32:0]                     w_sum;
    logic [31:0]                     w_run_adv;
    logic                            w_armed;

    // decisions shared by next-state and output logic
    logic                  d_arm;
    logic                  d_straight;
    logic                  d_follow;
    logic                  d_stop;
    lfb_pkg::t_reason      d_why;
    logic [7:0]            d_cnt;

    assign w_black   = i_item.line_ready ? count_black(i_item.black_mask) : '0;
    assign w_on_bar  = (w_black >= i_cfg.bar_min_black) && (w_black <= i_cfg.bar_max_black);
    assign w_bumped  = (i_state.confirm_count < lfb_pkg::CONFIRM_MAX) ?
                       i_state.confirm_count + 8'd1 : i_state.confirm_count;
    // advance only while run + period stays below all-ones
    assign w_sum     = {1'b0, i_state.run_ms} + {23'd0, i_cfg.tick_period_ms};
    assign w_run_adv = (!w_sum[32] && (w_sum[31:0] != lfb_pkg::RUN_MS_MAX)) ?
                       w_sum[31:0] : i_state.run_ms;
    assign w_armed   = w_run_adv >= {16'd0, i_cfg.stop_arm_ms};

    always_comb begin
        d_arm      = 1'b0;
        d_straight = 1'b0;
        d_follow   = 1'b0;
        d_stop     = 1'b0;
        d_why      = lfb_pkg::WHY_NONE;
        d_cnt      = i_state.confirm_count;
        if (i_item.action) begin
            if (i_state.phase == lfb_pkg::PH_IDLE) begin
                d_arm = i_item.drive_enabled && i_item.line_ready;
            end else begin
                d_stop = 1'b1;
                d_why  = lfb_pkg::WHY_CANCEL;
            end
        end else if (i_state.phase != lfb_pkg::PH_IDLE) begin
            if (!i_item.line_enabled) begin
                d_stop = 1'b1;
                d_why  = lfb_pkg::WHY_NOLINE;
            end else begin
                unique case (i_state.phase)
                    lfb_pkg::PH_WAIT: begin
                        if (w_on_bar) begin
                            d_cnt      = w_bumped;
                            d_straight = w_bumped >= i_cfg.start_confirm_ticks;
                        end else begin
                            d_cnt = 8'd0;
                        end
                    end
                    lfb_pkg::PH_LEAVE: begin
                        if (!w_on_bar) begin
                            d_cnt    = w_bumped;
                            d_follow = w_bumped >= i_cfg.leave_confirm_ticks;
                        end else begin
                            d_cnt = 8'd0;
                        end
                        if (!i_item.chassis_active && !d_follow) begin
                            d_stop = 1'b1;
                            d_why  = lfb_pkg::WHY_IDLE;
                        end
                    end
                    lfb_pkg::PH_TRACK: begin
                        if (w_armed && w_on_bar) begin
                            d_cnt = w_bumped;
                            if (w_bumped >= i_cfg.stop_confirm_ticks) begin
                                d_stop = 1'b1;
                                d_why  = lfb_pkg::WHY_STOPBAR;
                            end
                        end else begin
                            d_cnt = 8'd0;
                        end
                        if (!d_stop && !i_item.follow_active) begin
                            d_stop = 1'b1;
                            d_why  = lfb_pkg::WHY_IDLE;
                        end
                    end
                    lfb_pkg::PH_IDLE: begin
                        d_cnt = i_state.confirm_count;
                    end
                endcase
            end
        end
    end

    // next state
    always_comb begin
        o_state = i_state;
        priority if (d_stop) begin
            o_state.phase         = lfb_pkg::PH_IDLE;
            o_state.confirm_count = 8'd0;
            o_state.run_ms        = 32'd0;
        end else if (d_arm || d_straight || d_follow) begin
            o_state.phase         = d_arm      ? lfb_pkg::PH_WAIT :
                                    d_straight ? lfb_pkg::PH_LEAVE : lfb_pkg::PH_TRACK;
            o_state.confirm_count = 8'd0;
            o_state.run_ms        = 32'd0;
        end else if (i_state.phase == lfb_pkg::PH_TRACK) begin
            o_state.confirm_count = d_cnt;
            o_state.run_ms        = w_run_adv;
        end else begin
            o_state.confirm_count = d_cnt;
        end
    end

    // result fields
    always_comb begin
        o_result                = '0;
        o_result.motor_cmd      = lfb_pkg::CMD_NONE;
        o_result.stop_reason    = lfb_pkg::WHY_NONE;
        o_result.run_phase      = o_state.phase;
        priority if (d_stop) begin
            o_result.motor_cmd   = lfb_pkg::CMD_STOP;
            o_result.stop_reason = d_why;
            o_result.chirp_count = (d_why == lfb_pkg::WHY_STOPBAR) ?
                                   lfb_pkg::CHIRP_BAR : lfb_pkg::CHIRP_NONE;
            if (i_state.phase == lfb_pkg::PH_TRACK) begin
                o_result.run_time_valid = 1'b1;
                // bar and follow-lost stops see the advanced time
                o_result.run_time_ms = ((d_why == lfb_pkg::WHY_STOPBAR) ||
                                        (d_why == lfb_pkg::WHY_IDLE)) ?
                                       w_run_adv : i_state.run_ms;
            end
        end else if (d_arm) begin
            o_result.motor_cmd   = lfb_pkg::CMD_STOP;
            o_result.chirp_count = lfb_pkg::CHIRP_ARM;
        end else if (d_straight) begin
            o_result.motor_cmd = lfb_pkg::CMD_STRAIGHT;
            o_result.drive_rpm = (i_cfg.straight_rpm == 10'd0) ?
                                 lfb_pkg::DEFAULT_RPM : i_cfg.straight_rpm;
        end else if (d_follow) begin
            o_result.motor_cmd = lfb_pkg::CMD_FOLLOW;
        end
    end

endmodule

// ----- rtl/core/lfb_chk.sv -----
// Port-level checker for the line-follow bar sequencer, bound to the top.
// Depends on lfb_pkg for result codes.
module lfb_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lfb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic [1:0] w_cmd;
    logic [9:0] w_rpm;
    logic [1:0] w_chirp;
    logic [2:0] w_why;
    logic       w_tvld;
    logic [1:0] w_phase;

    assign w_cmd   = m_axis_tdata[1:0];
    assign w_rpm   = m_axis_tdata[11:2];
    assign w_chirp = m_axis_tdata[13:12];
    assign w_why   = m_axis_tdata[16:14];
    assign w_tvld  = m_axis_tdata[17];
    assign w_phase = m_axis_tdata[51:50];

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // no result right after reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // straight drive moves into the leave phase with a nonzero speed
    a_straight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_cmd == lfb_pkg::CMD_STRAIGHT) |->
        (w_rpm != 10'd0) && (w_phase == lfb_pkg::PH_LEAVE))
        else $error("bad straight drive result");

    // stop bar chirps twice, reports a run time and ends in idle
    a_bar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_chirp == lfb_pkg::CHIRP_BAR) |->
        (w_why == lfb_pkg::WHY_STOPBAR) && w_tvld && (w_cmd == lfb_pkg::CMD_STOP) &&
        (w_phase == lfb_pkg::PH_IDLE))
        else $error("bad stop bar result");

    // a stop command either arms (wait phase) or ends the run
    a_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_cmd == lfb_pkg::CMD_STOP) |->
        (w_phase == lfb_pkg::PH_IDLE) ||
        ((w_phase == lfb_pkg::PH_WAIT) && (w_chirp == lfb_pkg::CHIRP_ARM)))
        else $error("stop command in wrong phase");

endmodule

bind line_follow_bar_sequencer lfb_chk u_lfb_chk (.*);
